### rtl/pfrp_pkg.sv
package pfrp_pkg;

    localparam int VIRTUAL_PAGES_DEF = 64;
    localparam int MAX_FRAMES_DEF    = 16;
    localparam int ADDR_W            = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int S_TDATA_W         = 40;
    localparam int M_TDATA_W         = 56;
    localparam int OUT_PAGE_W        = 6;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_CLOCK   = 3'd4;

    localparam logic [2:0] CAUSE_RD_ABSENT  = 3'd0;
    localparam logic [2:0] CAUSE_WR_ABSENT  = 3'd1;
    localparam logic [2:0] CAUSE_WR_RDONLY  = 3'd2;
    localparam logic [2:0] CAUSE_RD_TRACKED = 3'd3;
    localparam logic [2:0] CAUSE_WR_TRACKED = 3'd4;
    localparam logic [2:0] CAUSE_OUT_RANGE  = 3'd5;

    localparam logic [1:0] PROT_NO = 2'd0;
    localparam logic [1:0] PROT_RD = 2'd1;
    localparam logic [1:0] PROT_RW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_READ,
        ST_EVAL,
        ST_FIFO_RD,
        ST_FIFO_EV,
        ST_CLK_TOUCH,
        ST_CLK_ISSUE,
        ST_CLK_PAGE,
        ST_COMMIT,
        ST_PHYS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic range_chk;
        logic rd_page;
        logic eval;
        logic fifo_rd;
        logic fifo_evict;
        logic clk_touch;
        logic clk_issue;
        logic clk_step;
        logic commit;
        logic phys;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic oor;
        logic allowed;
        logic has_frame;
        logic free_frame;
        logic use_clock;
        logic victim_found;
        logic out_free;
    } status_t;

endpackage

### rtl/pfrp_ctrl.sv
module pfrp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pfrp_pkg::status_t sts,
    output pfrp_pkg::cmd_t    cmd
);

    pfrp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfrp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfrp_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = pfrp_pkg::ST_RANGE;
            end
            pfrp_pkg::ST_RANGE: state_next = pfrp_pkg::ST_READ;
            pfrp_pkg::ST_READ: begin
                state_next = sts.oor ? pfrp_pkg::ST_EMIT : pfrp_pkg::ST_EVAL;
            end
            pfrp_pkg::ST_EVAL: begin
                priority if (sts.allowed) state_next = pfrp_pkg::ST_IDLE;
                else if (sts.has_frame) state_next = pfrp_pkg::ST_PHYS;
                else if (sts.free_frame) state_next = pfrp_pkg::ST_COMMIT;
                else if (sts.use_clock) state_next = pfrp_pkg::ST_CLK_TOUCH;
                else state_next = pfrp_pkg::ST_FIFO_RD;
            end
            pfrp_pkg::ST_FIFO_RD:   state_next = pfrp_pkg::ST_FIFO_EV;
            pfrp_pkg::ST_FIFO_EV:   state_next = pfrp_pkg::ST_COMMIT;
            pfrp_pkg::ST_CLK_TOUCH: state_next = pfrp_pkg::ST_CLK_ISSUE;
            pfrp_pkg::ST_CLK_ISSUE: state_next = pfrp_pkg::ST_CLK_PAGE;
            pfrp_pkg::ST_CLK_PAGE: begin
                state_next = sts.victim_found ? pfrp_pkg::ST_COMMIT
                                              : pfrp_pkg::ST_CLK_TOUCH;
            end
            pfrp_pkg::ST_COMMIT: state_next = pfrp_pkg::ST_PHYS;
            pfrp_pkg::ST_PHYS:   state_next = pfrp_pkg::ST_EMIT;
            pfrp_pkg::ST_EMIT: begin
                if (sts.out_free) state_next = pfrp_pkg::ST_IDLE;
            end
            default: state_next = pfrp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            pfrp_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            pfrp_pkg::ST_RANGE:     cmd.range_chk  = 1'b1;
            pfrp_pkg::ST_READ:      cmd.rd_page    = 1'b1;
            pfrp_pkg::ST_EVAL:      cmd.eval       = 1'b1;
            pfrp_pkg::ST_FIFO_RD:   cmd.fifo_rd    = 1'b1;
            pfrp_pkg::ST_FIFO_EV:   cmd.fifo_evict = 1'b1;
            pfrp_pkg::ST_CLK_TOUCH: cmd.clk_touch  = 1'b1;
            pfrp_pkg::ST_CLK_ISSUE: cmd.clk_issue  = 1'b1;
            pfrp_pkg::ST_CLK_PAGE:  cmd.clk_step   = 1'b1;
            pfrp_pkg::ST_COMMIT:    cmd.commit     = 1'b1;
            pfrp_pkg::ST_PHYS:      cmd.phys       = 1'b1;
            pfrp_pkg::ST_EMIT:      cmd.emit       = sts.out_free;
            default: ;
        endcase
    end

endmodule

### rtl/pfrp_dpath.sv
module pfrp_dpath #(
    parameter int VIRTUAL_PAGES = pfrp_pkg::VIRTUAL_PAGES_DEF,
    parameter int MAX_FRAMES    = pfrp_pkg::MAX_FRAMES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [pfrp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pfrp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [pfrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfrp_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  pfrp_pkg::cmd_t                   cmd,
    output pfrp_pkg::status_t                sts
);

    localparam int PW  = (VIRTUAL_PAGES > 1) ? $clog2(VIRTUAL_PAGES) : 1;
    localparam int CW  = $clog2(VIRTUAL_PAGES + 1);
    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NFW = $clog2(MAX_FRAMES + 1);
    localparam int AW  = pfrp_pkg::ADDR_W;

    typedef struct packed {
        logic [1:0]    prot;
        logic          hf;
        logic [FW-1:0] frame;
        logic          ro;
        logic          refd;
        logic [1:0]    wb;
        logic          listed;
    } rec_t;

    // configuration
    logic [AW-1:0] base_reg, size_reg;
    logic [4:0]    shift_reg, fcount_reg;
    logic          clock_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            size_reg   <= 32'd65536;
            shift_reg  <= 5'd12;
            fcount_reg <= 5'd16;
            clock_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pfrp_pkg::REG_REGION_BASE: base_reg   <= cfg_wr_data;
                pfrp_pkg::REG_REGION_SIZE: size_reg   <= cfg_wr_data;
                pfrp_pkg::REG_PAGE_SHIFT:  shift_reg  <= cfg_wr_data[4:0];
                pfrp_pkg::REG_FRAME_COUNT: fcount_reg <= cfg_wr_data[4:0];
                pfrp_pkg::REG_USE_CLOCK:   clock_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // usable frame count: zero acts as one, clamp to the frame pool
    logic [NFW-1:0] nf;
    always_comb begin
        if (fcount_reg == 5'd0) nf = NFW'(1);
        else if (32'(fcount_reg) > 32'(MAX_FRAMES)) nf = NFW'(MAX_FRAMES);
        else nf = NFW'(fcount_reg);
    end

    // item registers
    logic [AW-1:0] addr_reg, off_reg, phys_reg;
    logic          wr_reg, oor_reg;
    logic [PW-1:0] pg_reg, ev_page_reg, cp_reg;
    logic [2:0]    cause_reg;
    logic [FW-1:0] frame_reg;
    logic          ev_valid_reg, dirty_reg, self_reg;
    rec_t          pgnew_reg;

    // table state
    rec_t           page_mem [VIRTUAL_PAGES];
    logic [VIRTUAL_PAGES-1:0] page_vld_reg;
    rec_t           rec_q_reg;
    logic           rec_vq_reg;
    logic [PW-1:0]  touch_mem [VIRTUAL_PAGES];
    logic [PW-1:0]  touch_q_reg;
    logic [PW-1:0]  fifo_mem [MAX_FRAMES];
    logic [PW-1:0]  fifo_q_reg;
    logic [CW-1:0]  count_reg, hand_reg;
    logic [FW-1:0]  head_reg;
    logic [NFW-1:0] used_reg;

    rec_t rec_rd, hit_rec, miss_rec, vic_rec, clk_rec, fin_rec;
    logic [2:0] hit_cause, miss_cause;
    logic [FW-1:0] head_sel;
    logic [NFW:0]  head_inc;
    logic [CW:0]   hand_inc;
    logic          pm_we, pm_re;
    logic [PW-1:0] pm_wa, pm_ra;
    rec_t          pm_wd;

    logic [AW-1:0] rel;
    logic [AW-1:0] pg_full;

    assign rec_rd   = rec_vq_reg ? rec_q_reg : '0;
    assign rel      = addr_reg - base_reg;
    assign pg_full  = rel >> shift_reg;
    assign head_sel = (32'(head_reg) >= 32'(nf)) ? '0 : head_reg;
    assign head_inc = (NFW+1)'(head_sel) + (NFW+1)'(1);
    assign hand_inc = {1'b0, hand_reg} + (CW+1)'(1);

    always_comb begin
        hit_rec   = rec_rd;
        hit_rec.refd = 1'b1;
        hit_cause = pfrp_pkg::CAUSE_WR_TRACKED;
        priority if (rec_rd.ro && wr_reg) begin
            hit_cause    = pfrp_pkg::CAUSE_WR_RDONLY;
            hit_rec.ro   = 1'b0;
            hit_rec.wb   = 2'b11;
            hit_rec.prot = pfrp_pkg::PROT_RW;
        end else if (!wr_reg) begin
            hit_cause    = pfrp_pkg::CAUSE_RD_TRACKED;
            hit_rec.prot = pfrp_pkg::PROT_RD;
        end else begin
            hit_rec.wb   = 2'b11;
            hit_rec.prot = pfrp_pkg::PROT_RW;
        end

        miss_rec = rec_rd;
        miss_rec.refd = 1'b1;
        if (!wr_reg) begin
            miss_cause    = pfrp_pkg::CAUSE_RD_ABSENT;
            miss_rec.ro   = 1'b1;
            miss_rec.prot = pfrp_pkg::PROT_RD;
        end else begin
            miss_cause    = pfrp_pkg::CAUSE_WR_ABSENT;
            miss_rec.wb   = 2'b11;
            miss_rec.prot = pfrp_pkg::PROT_RW;
        end

        // FIFO victim: full reset, keeps its list mark
        vic_rec = (ev_page_reg == pg_reg) ? pgnew_reg : rec_rd;
        vic_rec.prot = pfrp_pkg::PROT_NO;
        vic_rec.hf   = 1'b0;
        vic_rec.ro   = 1'b0;
        vic_rec.refd = 1'b0;
        vic_rec.wb   = 2'b00;

        clk_rec = rec_rd;
        clk_rec.prot = pfrp_pkg::PROT_NO;
        priority if (rec_rd.refd) begin
            clk_rec.refd = 1'b0;
        end else if (rec_rd.wb[1]) begin
            clk_rec.wb = 2'b01;
        end else begin
            clk_rec.wb = 2'b00;
            clk_rec.hf = 1'b0;
        end

        fin_rec = pgnew_reg;
        if (self_reg) begin
            fin_rec.prot = pfrp_pkg::PROT_NO;
            fin_rec.ro   = 1'b0;
            fin_rec.refd = 1'b0;
            fin_rec.wb   = 2'b00;
        end
        fin_rec.hf     = 1'b1;
        fin_rec.frame  = frame_reg;
        fin_rec.listed = 1'b1;
    end

    always_comb begin
        sts.oor          = oor_reg;
        sts.allowed      = (rec_rd.prot >= pfrp_pkg::PROT_RW) ||
                           (rec_rd.prot == pfrp_pkg::PROT_RD && !wr_reg);
        sts.has_frame    = rec_rd.hf;
        sts.free_frame   = used_reg < nf;
        sts.use_clock    = clock_reg;
        sts.victim_found = rec_rd.hf && !rec_rd.refd && !rec_rd.wb[1];
        sts.out_free     = !m_tvalid || m_tready;
    end

    // page table port selection
    always_comb begin
        pm_we = 1'b0;
        pm_wa = pg_reg;
        pm_wd = fin_rec;
        pm_re = cmd.rd_page || cmd.fifo_rd || cmd.clk_issue;
        pm_ra = pg_reg;
        if (cmd.fifo_rd) pm_ra = fifo_q_reg;
        if (cmd.clk_issue) pm_ra = touch_q_reg;
        if (cmd.eval && !sts.allowed && rec_rd.hf) begin
            pm_we = 1'b1;
            pm_wd = hit_rec;
        end
        if (cmd.fifo_evict && ev_page_reg != pg_reg) begin
            pm_we = 1'b1;
            pm_wa = ev_page_reg;
            pm_wd = vic_rec;
        end
        if (cmd.clk_step && rec_rd.hf) begin
            pm_we = 1'b1;
            pm_wa = cp_reg;
            pm_wd = clk_rec;
        end
        if (cmd.commit) pm_we = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (pm_we) page_mem[pm_wa] <= pm_wd;
        if (pm_re) begin
            rec_q_reg  <= page_mem[pm_ra];
            rec_vq_reg <= page_vld_reg[pm_ra];
        end
        if (cmd.clk_touch) touch_q_reg <= touch_mem[hand_reg[PW-1:0]];
        if (cmd.commit && !pgnew_reg.listed) touch_mem[count_reg[PW-1:0]] <= pg_reg;
        if (cmd.eval) fifo_q_reg <= fifo_mem[head_sel];
        if (cmd.commit) fifo_mem[frame_reg] <= pg_reg;
    end

    // control state of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_vld_reg <= '0;
            count_reg    <= '0;
            hand_reg     <= '0;
            head_reg     <= '0;
            used_reg     <= '0;
        end else begin
            if (pm_we) page_vld_reg[pm_wa] <= 1'b1;
            if (cmd.commit && !pgnew_reg.listed) count_reg <= count_reg + CW'(1);
            if (cmd.eval && !sts.allowed && !rec_rd.hf) begin
                if (sts.free_frame) begin
                    used_reg <= used_reg + NFW'(1);
                end else if (clock_reg) begin
                    if (hand_reg >= count_reg) hand_reg <= '0;
                end else begin
                    head_reg <= (head_inc >= (NFW+1)'(nf)) ? '0 : FW'(head_inc);
                end
            end
            if (cmd.clk_touch) begin
                hand_reg <= (hand_inc >= {1'b0, count_reg}) ? '0 : CW'(hand_inc);
            end
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg     <= s_tdata[AW-1:0];
            wr_reg       <= s_tdata[AW];
            cause_reg    <= pfrp_pkg::CAUSE_OUT_RANGE;
            frame_reg    <= '0;
            ev_valid_reg <= 1'b0;
            ev_page_reg  <= '0;
            dirty_reg    <= 1'b0;
            self_reg     <= 1'b0;
            phys_reg     <= '0;
        end
        if (cmd.range_chk) begin
            oor_reg <= (addr_reg < base_reg) || (rel >= size_reg) ||
                       (pg_full >= AW'(VIRTUAL_PAGES));
            pg_reg  <= pg_full[PW-1:0];
            off_reg <= rel & ~({AW{1'b1}} << shift_reg);
        end
        if (cmd.eval && !sts.allowed) begin
            if (rec_rd.hf) begin
                cause_reg <= hit_cause;
                frame_reg <= rec_rd.frame;
            end else begin
                cause_reg <= miss_cause;
                pgnew_reg <= miss_rec;
                if (sts.free_frame) begin
                    frame_reg <= FW'(used_reg);
                end else if (!clock_reg) begin
                    frame_reg    <= head_sel;
                    ev_valid_reg <= 1'b1;
                end
            end
        end
        if (cmd.fifo_rd) ev_page_reg <= fifo_q_reg;
        if (cmd.fifo_evict) begin
            dirty_reg <= ((ev_page_reg == pg_reg) ? pgnew_reg.wb : rec_rd.wb) != 2'b00;
            self_reg  <= ev_page_reg == pg_reg;
        end
        if (cmd.clk_issue) cp_reg <= touch_q_reg;
        if (cmd.clk_step && sts.victim_found) begin
            dirty_reg    <= rec_rd.wb[0];
            ev_page_reg  <= cp_reg;
            ev_valid_reg <= 1'b1;
            frame_reg    <= rec_rd.frame;
        end
        if (cmd.phys) phys_reg <= (AW'(frame_reg) << shift_reg) + off_reg;
    end

    // result register
    localparam int OUTW = pfrp_pkg::M_TDATA_W;
    logic                  m_valid_reg;
    logic [OUTW-1:0]       m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {7'b0, phys_reg, dirty_reg,
                           pfrp_pkg::OUT_PAGE_W'(ev_page_reg), ev_valid_reg, cause_reg,
                           oor_reg ? pfrp_pkg::OUT_PAGE_W'(0)
                                   : pfrp_pkg::OUT_PAGE_W'(pg_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(VIRTUAL_PAGES))
        else $error("touch list overflow");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) <= 32'(MAX_FRAMES))
        else $error("frame use count overflow");
    a_evict_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && ev_valid_reg |->
            (cause_reg == pfrp_pkg::CAUSE_RD_ABSENT ||
             cause_reg == pfrp_pkg::CAUSE_WR_ABSENT))
        else $error("eviction on a fault without replacement");
    a_oor_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && oor_reg |-> !ev_valid_reg && phys_reg == '0 &&
            cause_reg == pfrp_pkg::CAUSE_OUT_RANGE)
        else $error("out of range report carries data");
`endif

endmodule

### rtl/page_fault_replacement_policy_core.sv
// Channel | Direction | Handshake         | Payload
// s_      | in        | s_tvalid/s_tready | s_tdata: access_address[31:0], is_write[32]
// m_      | out       | m_tvalid/m_tready | m_tdata: fault report, see port
// cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wr_data
//
// One item at a time: a new access is accepted only in the idle state. A clock
// eviction moves the hand over the listed pages until it finds a victim: each visit
// is a list read then a page table read through the one read port of the page memory.
// Reset (aresetn, synchronous, low) empties the page table through per-page
// valid bits, with no clearing pass. A stalled result holds the next
// report in the emit state until m_tready.
module page_fault_replacement_policy_core #(
    parameter int VIRTUAL_PAGES = pfrp_pkg::VIRTUAL_PAGES_DEF,
    parameter int MAX_FRAMES    = pfrp_pkg::MAX_FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] access_address, [32] is_write, [39:33] zero
    input  logic [pfrp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] virtual_page, [8:6] cause, [9] evicted_valid, [15:10] evicted_page,
    // [16] write_back, [48:17] physical_address, [55:49] zero
    output logic [pfrp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [pfrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfrp_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    pfrp_pkg::cmd_t    cmd;
    pfrp_pkg::status_t sts;

    pfrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfrp_dpath #(
        .VIRTUAL_PAGES (VIRTUAL_PAGES),
        .MAX_FRAMES    (MAX_FRAMES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

### test/tb_page_fault_replacement_policy_core.sv
module tb_page_fault_replacement_policy_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES    = 64;
    localparam int NFRAMES   = 16;
    localparam int SWEEP_MAX = 4 * NPAGES + 4;
    localparam int SETTLE    = 1000;
    localparam int STALL_LIM = 20000;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] phys_addr;
        logic        write_back;
        logic [5:0]  evicted_page;
        logic        evicted_valid;
        logic [2:0]  cause;
        logic [5:0]  virtual_page;
    } fault_report_t;

    typedef struct {
        logic [31:0] addr;
        logic        wr;
    } access_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pfrp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pfrp_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [pfrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pfrp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    page_fault_replacement_policy_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow page table and registers
    logic [31:0] r_base = 32'd0;
    logic [31:0] r_size = 32'd65536;
    int unsigned r_shift = 12;
    int unsigned r_fcount = 16;
    logic r_clock = 1'b0;

    logic [1:0] pt_prot[NPAGES];
    logic pt_has_frame[NPAGES];
    int unsigned pt_frame[NPAGES];
    logic pt_ro[NPAGES];
    logic pt_ref[NPAGES];
    logic [1:0] pt_wbits[NPAGES];
    logic pt_listed[NPAGES];
    int unsigned touch_list[NPAGES];
    int unsigned touch_cnt = 0;
    int unsigned frame_owner[NFRAMES];
    int unsigned ring_head = 0;
    int unsigned frames_taken = 0;
    int unsigned hand = 0;

    access_t pending_accesses[$];
    fault_report_t fault_reports_due[$];
    int errors = 0;
    int accesses_taken = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    initial begin
        for (int i = 0; i < NPAGES; i++) begin
            pt_prot[i] = pfrp_pkg::PROT_NO; pt_has_frame[i] = 0; pt_frame[i] = 0;
            pt_ro[i] = 0; pt_ref[i] = 0; pt_wbits[i] = 0; pt_listed[i] = 0;
            touch_list[i] = 0;
        end
        for (int i = 0; i < NFRAMES; i++) frame_owner[i] = 0;
    end

    function automatic int unsigned usable_frames();
        if (r_fcount == 0) return 1;
        if (r_fcount > NFRAMES) return NFRAMES;
        return r_fcount;
    endfunction

    function automatic bit fault_predict(input logic [31:0] addr, input logic wr,
                                         output fault_report_t rpt);
        logic [63:0] rel, off, pa;
        int unsigned pg, nf, frame, evp, pos, vp;
        logic [2:0] cause;
        bit evv, dirty, found;
        rpt = '0;
        rpt.cause = pfrp_pkg::CAUSE_OUT_RANGE;
        frame = 0; evv = 0; dirty = 0; evp = 0;
        if (addr < r_base) return 1;
        rel = {32'd0, addr} - {32'd0, r_base};
        if (rel >= {32'd0, r_size}) return 1;
        if ((rel >> r_shift) >= NPAGES) return 1;
        pg = int'(rel >> r_shift);
        off = rel & ((64'd1 << r_shift) - 64'd1);
        if (pt_prot[pg] >= pfrp_pkg::PROT_RW) return 0;
        if (pt_prot[pg] == pfrp_pkg::PROT_RD && !wr) return 0;
        pt_ref[pg] = 1;
        if (pt_has_frame[pg]) begin
            if (pt_ro[pg] && wr) begin
                cause = pfrp_pkg::CAUSE_WR_RDONLY; pt_ro[pg] = 0;
                pt_wbits[pg] = 2'd3; pt_prot[pg] = pfrp_pkg::PROT_RW;
            end else if (!wr) begin
                cause = pfrp_pkg::CAUSE_RD_TRACKED; pt_prot[pg] = pfrp_pkg::PROT_RD;
            end else begin
                cause = pfrp_pkg::CAUSE_WR_TRACKED; pt_wbits[pg] = 2'd3;
                pt_prot[pg] = pfrp_pkg::PROT_RW;
            end
            frame = pt_frame[pg];
        end else begin
            nf = usable_frames();
            if (!wr) begin
                cause = pfrp_pkg::CAUSE_RD_ABSENT; pt_ro[pg] = 1;
                pt_prot[pg] = pfrp_pkg::PROT_RD;
            end else begin
                cause = pfrp_pkg::CAUSE_WR_ABSENT; pt_wbits[pg] = 2'd3;
                pt_prot[pg] = pfrp_pkg::PROT_RW;
            end
            if (frames_taken < nf) begin
                frame = frames_taken;
                frames_taken++;
            end else if (r_clock) begin
                // third chance: referenced, then recently written, then evict
                if (hand >= touch_cnt) hand = 0;
                found = 0;
                for (int step = 0; step < SWEEP_MAX && !found; step++) begin
                    pos = hand;
                    vp = touch_list[pos % NPAGES] % NPAGES;
                    hand = (pos + 1 >= touch_cnt) ? 0 : pos + 1;
                    if (pt_has_frame[vp]) begin
                        pt_prot[vp] = pfrp_pkg::PROT_NO;
                        if (pt_ref[vp]) pt_ref[vp] = 0;
                        else if (pt_wbits[vp][1]) pt_wbits[vp] = 2'd1;
                        else begin
                            dirty = pt_wbits[vp][0];
                            pt_wbits[vp] = 0; pt_has_frame[vp] = 0;
                            evp = vp; found = 1;
                        end
                    end
                end
                if (!found) begin
                    dirty = 0; evp = 0;
                end
                evv = 1;
                frame = pt_frame[evp];
            end else begin
                if (ring_head >= nf) ring_head = 0;
                frame = ring_head;
                evp = frame_owner[frame % NFRAMES] % NPAGES;
                evv = 1;
                dirty = pt_wbits[evp] != 0;
                pt_prot[evp] = pfrp_pkg::PROT_NO; pt_has_frame[evp] = 0; pt_ro[evp] = 0;
                pt_ref[evp] = 0; pt_wbits[evp] = 0;
                ring_head = (ring_head + 1 >= nf) ? 0 : ring_head + 1;
            end
            frame = frame % NFRAMES;
            pt_frame[pg] = frame;
            pt_has_frame[pg] = 1;
            frame_owner[frame] = pg;
            if (!pt_listed[pg] && touch_cnt < NPAGES) begin
                touch_list[touch_cnt] = pg;
                touch_cnt++;
                pt_listed[pg] = 1;
            end
        end
        pa = ((64'(frame) << r_shift) + off) & 64'hFFFF_FFFF;
        rpt.virtual_page = pg[5:0];
        rpt.cause = cause;
        rpt.evicted_valid = evv;
        rpt.evicted_page = evp[5:0];
        rpt.write_back = dirty;
        rpt.phys_addr = pa[31:0];
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    int gap = 0;
    access_t cur;
    fault_report_t pred;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                accesses_taken++;
                if (fault_predict(s_tdata[31:0], s_tdata[32], pred))
                    fault_reports_due.push_back(pred);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_accesses.size() > 0) begin
                    cur = pending_accesses.pop_front();
                    s_tdata <= {7'd0, cur.wr, cur.addr};
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 11);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    int rgap = 0;
    int hold_cnt = 0;
    bit held = 1'b0;
    fault_report_t got, want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (fault_reports_due.size() == 0) begin
                    report_mismatch("unexpected report, physical_address",
                                    got.phys_addr, 32'd0);
                end else begin
                    want = fault_reports_due.pop_front();
                    if (got.virtual_page != want.virtual_page)
                        report_mismatch("virtual_page", got.virtual_page, want.virtual_page);
                    if (got.cause != want.cause)
                        report_mismatch("cause", got.cause, want.cause);
                    if (got.evicted_valid != want.evicted_valid)
                        report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
                    if (got.evicted_page != want.evicted_page)
                        report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
                    if (got.write_back != want.write_back)
                        report_mismatch("write_back", got.write_back, want.write_back);
                    if (got.phys_addr != want.phys_addr)
                        report_mismatch("physical_address", got.phys_addr, want.phys_addr);
                end
            end
            if (hold_req && !held) begin
                // long hold-off: let the block back up into its input
                held <= 1'b1;
                hold_cnt <= 300;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (rgap > 0) begin
                rgap <= rgap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0) rgap <= $urandom_range(1, 11);
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [pfrp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        case (idx)
            pfrp_pkg::REG_REGION_BASE: r_base = data;
            pfrp_pkg::REG_REGION_SIZE: r_size = data;
            pfrp_pkg::REG_PAGE_SHIFT:  r_shift = data & 32'd31;
            pfrp_pkg::REG_FRAME_COUNT: r_fcount = data & 32'd31;
            pfrp_pkg::REG_USE_CLOCK:   r_clock = data[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_region(input logic [31:0] base, input logic [31:0] size,
                              input int unsigned shift, input int unsigned fcount,
                              input logic clk_mode);
        write_reg(pfrp_pkg::REG_REGION_BASE, base);
        write_reg(pfrp_pkg::REG_REGION_SIZE, size);
        write_reg(pfrp_pkg::REG_PAGE_SHIFT, shift);
        write_reg(pfrp_pkg::REG_FRAME_COUNT, fcount);
        write_reg(pfrp_pkg::REG_USE_CLOCK, {31'd0, clk_mode});
    endtask

    task automatic push_access(input logic [31:0] addr, input logic wr);
        access_t a;
        a.addr = addr;
        a.wr = wr;
        pending_accesses.push_back(a);
    endtask

    // mostly accesses to twice as many pages as frames plus three, some at edges
    task automatic push_random(input int n);
        int unsigned span, pg;
        logic [63:0] a;
        for (int i = 0; i < n; i++) begin
            span = 2 * usable_frames() + 3;
            if (span > NPAGES + 2) span = NPAGES + 2;
            case ($urandom_range(0, 9))
                0: a = {32'd0, $urandom()};
                1: case ($urandom_range(0, 3))
                       0: a = {32'd0, r_base} - 64'd1;
                       1: a = {32'd0, r_base} + {32'd0, r_size};
                       2: a = {32'd0, r_base} + {32'd0, r_size} - 64'd1;
                       default: a = {32'd0, r_base};
                   endcase
                default: begin
                    pg = $urandom_range(0, span - 1);
                    a = {32'd0, r_base} + (64'(pg) << r_shift)
                        + (64'($urandom()) & ((64'd1 << r_shift) - 64'd1));
                end
            endcase
            push_access(a[31:0], $urandom_range(0, 1) == 1);
        end
    endtask

    task automatic drain();
        while (pending_accesses.size() > 0 || s_tvalid || fault_reports_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: 16 pages of 4 KiB, 16 frames, FIFO
        push_access(32'h0000_0000, 1'b0);
        push_access(32'h0000_0004, 1'b0);
        push_access(32'h0000_0008, 1'b1);
        push_access(32'h0000_0010, 1'b1);
        push_access(32'h0000_1FFF, 1'b1);
        push_access(32'h0000_1000, 1'b0);
        push_access(32'h0000_2000, 1'b0);
        push_access(32'h0000_2004, 1'b1);
        push_access(32'h0000_FFFF, 1'b0);
        push_access(32'h0001_0000, 1'b0);
        push_access(32'hFFFF_FFFF, 1'b1);
        push_access(32'h0000_0000, 1'b1);
        drain();

        // clock policy, tiny pages, few frames; long receiver hold-off here
        set_region(32'h1000_0000, 32'd1024, 4, 4, 1'b1);
        push_access(32'h0FFF_FFFF, 1'b0);
        push_access(32'h1000_0400, 1'b1);
        push_access(32'h1000_03FF, 1'b1);
        push_random(90);
        @(posedge aclk);
        hold_req <= 1'b1;
        drain();

        set_region(32'h0000_0000, 32'hFFFF_FFFF, 20, 16, 1'b0);
        push_random(60);
        drain();

        // byte pages at the top of the address space, a single frame
        set_region(32'hFFFF_FFC0, 32'd64, 0, 1, 1'b1);
        push_random(60);
        drain();

        set_region($urandom(), 32'd1, 3, 0, 1'b0);
        push_random(20);
        drain();

        set_region(32'h0000_8000, 32'h0000_8000, 9, 31, 1'b1);
        push_random(60);
        drain();

        write_reg(pfrp_pkg::REG_PAGE_SHIFT, 32'd31);
        push_random(20);
        drain();

        set_region(32'h0000_0000, 32'd4096, 6, 3, 1'b0);
        push_random(50);
        drain();

        // last stretch: no idling on either side
        quiet = 1'b1;
        write_reg(pfrp_pkg::REG_USE_CLOCK, 32'd1);
        push_random(80);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
